### hdl/front_matter_fence_detector_defines.svh
// ----------------------------------------------------------------------------
// Front-matter fence detector assertion macros
// Shared helpers for the concurrent checks in the detector RTL.
// ----------------------------------------------------------------------------
`ifndef FRONT_MATTER_FENCE_DETECTOR_DEFINES_SVH
`define FRONT_MATTER_FENCE_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FMFD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fmfd check failed");

// next-cycle implication, disabled during reset
`define FMFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fmfd check failed");

`endif

### hdl/fmfd_pkg.sv
// ----------------------------------------------------------------------------
// Front-matter fence detector package
// Widths, limits and beat/result types shared by the detector modules.
// ----------------------------------------------------------------------------
package fmfd_pkg;

  localparam int unsigned MAX_DOC_BYTES = 1048576;
  localparam int unsigned POS_W         = $clog2(MAX_DOC_BYTES + 1);
  localparam int unsigned OFFSET_W      = 21;
  localparam int unsigned LINE_W        = 16;
  localparam int unsigned BYTE_W        = 8;

  localparam logic [POS_W-1:0]  MAX_POS          = POS_W'(MAX_DOC_BYTES);
  localparam logic [LINE_W-1:0] LINE_LIMIT_RESET = 16'd1024;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] body_offset;
    logic                stripped;
    logic                limit_hit;
  } result_t;

endpackage

### hdl/fmfd_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one byte beat; frees itself when the scan stage takes it.
// ----------------------------------------------------------------------------
module fmfd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  fmfd_pkg::in_beat_t s_beat,
  input  logic              advance,
  output logic              in_valid,
  output fmfd_pkg::in_beat_t in_beat
);

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_beat <= s_beat;
    end
  end

endmodule

### hdl/fmfd_scan.sv
// ----------------------------------------------------------------------------
// Fence scanner
// Per-byte fence state machine, counters and the line limit register.
// ----------------------------------------------------------------------------
module fmfd_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fmfd_pkg::LINE_W-1:0]   cfg_wr_data,
  input  logic                          step,
  input  fmfd_pkg::in_beat_t            beat,
  output fmfd_pkg::result_t             result
);

  typedef enum logic [3:0] {
    PH_BOM0, PH_BOM1, PH_BOM2, PH_OPEN_FIRST, PH_OPEN_MARK, PH_OPEN_BLANKS,
    PH_OPEN_CR, PH_LINE_START, PH_CLOSE_MARK, PH_CLOSE_BLANKS, PH_CLOSE_CR,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    OC_PENDING, OC_STRIPPED, OC_UNCHANGED, OC_LIMIT
  } outcome_t;

  localparam logic [7:0] BOM_B0 = 8'hEF;
  localparam logic [7:0] BOM_B1 = 8'hBB;
  localparam logic [7:0] BOM_B2 = 8'hBF;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DASH = 2'd1;
  localparam logic [1:0] KIND_PLUS = 2'd2;
  localparam logic [1:0] KIND_DOT  = 2'd3;

  function automatic logic [1:0] kind_of(input logic [7:0] b);
    logic [1:0] k;
    k = KIND_NONE;
    if (b == CH_DASH) k = KIND_DASH;
    else if (b == CH_PLUS) k = KIND_PLUS;
    else if (b == CH_DOT) k = KIND_DOT;
    return k;
  endfunction

  function automatic logic [7:0] char_of(input logic [1:0] k);
    logic [7:0] c;
    c = CH_DOT;
    if (k == KIND_DASH) c = CH_DASH;
    else if (k == KIND_PLUS) c = CH_PLUS;
    return c;
  endfunction

  logic [fmfd_pkg::LINE_W-1:0] line_limit;
  phase_t                      phase, phase_next;
  logic [fmfd_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [1:0]                  marker_kind, marker_kind_next;
  logic [1:0]                  marker_progress, marker_progress_next;
  logic [fmfd_pkg::LINE_W-1:0] lines_tried, lines_tried_next;
  logic [fmfd_pkg::POS_W-1:0]  found_offset, found_offset_next;
  outcome_t                    outcome, outcome_next;

  logic [7:0] b;
  logic       blank;
  logic [1:0] bk;
  logic [fmfd_pkg::POS_W-1:0] pos_inc;

  assign b       = beat.text_byte;
  assign blank   = (b == CH_SP) || (b == CH_TAB);
  assign bk      = kind_of(b);
  assign pos_inc = byte_position + 1'b1;

  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    marker_kind_next     = marker_kind;
    marker_progress_next = marker_progress;
    lines_tried_next     = lines_tried;
    found_offset_next    = found_offset;
    outcome_next         = outcome;

    if (outcome == OC_PENDING) begin
      if (byte_position >= fmfd_pkg::MAX_POS) begin
        outcome_next = OC_LIMIT;
      end else begin
        byte_position_next = pos_inc;
        unique case (phase)
          PH_BOM0, PH_OPEN_FIRST: begin
            if (phase == PH_BOM0 && b == BOM_B0) begin
              phase_next = PH_BOM1;
            end else if (bk == KIND_DASH || bk == KIND_PLUS) begin
              marker_kind_next     = bk;
              marker_progress_next = 2'd1;
              phase_next           = PH_OPEN_MARK;
            end else begin
              outcome_next = OC_UNCHANGED;
            end
          end
          PH_BOM1: begin
            if (b == BOM_B1) phase_next = PH_BOM2;
            else outcome_next = OC_UNCHANGED;
          end
          PH_BOM2: begin
            if (b == BOM_B2) phase_next = PH_OPEN_FIRST;
            else outcome_next = OC_UNCHANGED;
          end
          PH_OPEN_MARK, PH_CLOSE_MARK: begin
            if (b == char_of(marker_kind)) begin
              marker_progress_next = marker_progress + 2'd1;
              if (marker_progress == 2'd2) begin
                phase_next = (phase == PH_OPEN_MARK) ? PH_OPEN_BLANKS : PH_CLOSE_BLANKS;
              end
            end else if (phase == PH_OPEN_MARK) begin
              outcome_next = OC_UNCHANGED;
            end else begin
              phase_next = (b == CH_LF) ? PH_LINE_START : PH_SKIP;
            end
          end
          PH_OPEN_BLANKS: begin
            if (!blank) begin
              if (b == CH_LF) phase_next = PH_LINE_START;
              else if (b == CH_CR) phase_next = PH_OPEN_CR;
              else outcome_next = OC_UNCHANGED;
            end
          end
          PH_OPEN_CR: begin
            if (b == CH_LF) phase_next = PH_LINE_START;
            else outcome_next = OC_UNCHANGED;
          end
          PH_LINE_START: begin
            if (lines_tried >= line_limit) begin
              outcome_next = OC_LIMIT;
            end else begin
              lines_tried_next = lines_tried + 1'b1;
              marker_kind_next = bk;
              if (bk != KIND_NONE) begin
                marker_progress_next = 2'd1;
                phase_next           = PH_CLOSE_MARK;
              end else begin
                phase_next = (b == CH_LF) ? PH_LINE_START : PH_SKIP;
              end
            end
          end
          PH_CLOSE_BLANKS: begin
            if (!blank) begin
              if (b == CH_LF) begin
                found_offset_next = pos_inc;
                outcome_next      = OC_STRIPPED;
              end else if (b == CH_CR) begin
                phase_next = PH_CLOSE_CR;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
          PH_CLOSE_CR: begin
            if (b == CH_LF) begin
              found_offset_next = pos_inc;
              outcome_next      = OC_STRIPPED;
            end else begin
              phase_next = PH_SKIP;
            end
          end
          default: begin
            if (b == CH_LF) phase_next = PH_LINE_START;
          end
        endcase
      end
    end
  end

  // end-of-document decision on the updated state
  always_comb begin
    result = '0;
    if (outcome_next == OC_STRIPPED) begin
      result.body_offset = fmfd_pkg::OFFSET_W'(found_offset_next);
      result.stripped    = 1'b1;
    end else if (outcome_next == OC_LIMIT) begin
      result.limit_hit = 1'b1;
    end else if (outcome_next == OC_PENDING) begin
      if (phase_next == PH_CLOSE_BLANKS) begin
        result.body_offset = fmfd_pkg::OFFSET_W'(byte_position_next);
        result.stripped    = 1'b1;
      end else if (phase_next == PH_LINE_START && lines_tried_next >= line_limit) begin
        result.limit_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit      <= fmfd_pkg::LINE_LIMIT_RESET;
      phase           <= PH_BOM0;
      byte_position   <= '0;
      marker_kind     <= '0;
      marker_progress <= '0;
      lines_tried     <= '0;
      found_offset    <= '0;
      outcome         <= OC_PENDING;
    end else begin
      if (cfg_wr_en) begin
        line_limit <= cfg_wr_data;
      end
      if (step) begin
        if (beat.last_byte) begin
          phase           <= PH_BOM0;
          byte_position   <= '0;
          marker_kind     <= '0;
          marker_progress <= '0;
          lines_tried     <= '0;
          found_offset    <= '0;
          outcome         <= OC_PENDING;
        end else begin
          phase           <= phase_next;
          byte_position   <= byte_position_next;
          marker_kind     <= marker_kind_next;
          marker_progress <= marker_progress_next;
          lines_tried     <= lines_tried_next;
          found_offset    <= found_offset_next;
          outcome         <= outcome_next;
        end
      end
    end
  end

endmodule

### hdl/fmfd_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module fmfd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  fmfd_pkg::result_t load_result,
  output logic              free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output fmfd_pkg::result_t m_result
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load) begin
      m_result <= load_result;
    end
  end

endmodule

### hdl/front_matter_fence_detector.sv
// ----------------------------------------------------------------------------
// Front-matter fence detector
// A final byte is held in the input register; its scan result then loads the result register.
// Throughput: one byte beat per cycle, except while a final byte waits for the result register.
// A final byte waits in the input register only while a result is unread.
// Reset (rst, synchronous): clears all scan state, line_limit returns to 1024.
// ----------------------------------------------------------------------------
`include "front_matter_fence_detector_defines.svh"

module front_matter_fence_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,  // line_limit
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] text_byte
  input  logic        s_tlast,      // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,      // [20:0] body_offset, [23:21] zero
  output logic [1:0]  m_tuser       // [0] stripped, [1] limit_hit
);

  fmfd_pkg::in_beat_t s_beat, in_beat;
  fmfd_pkg::result_t  scan_result, m_result;
  logic in_valid, advance, out_free;

  assign s_beat.text_byte = s_tdata;
  assign s_beat.last_byte = s_tlast;
  assign advance = in_valid && (!in_beat.last_byte || out_free);

  fmfd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_beat   (s_beat),
    .advance  (advance),
    .in_valid (in_valid),
    .in_beat  (in_beat)
  );

  fmfd_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (advance),
    .beat        (in_beat),
    .result      (scan_result)
  );

  fmfd_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && in_beat.last_byte),
    .load_result (scan_result),
    .free        (out_free),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_result    (m_result)
  );

  assign m_tdata = {3'b000, m_result.body_offset};
  assign m_tuser = {m_result.limit_hit, m_result.stripped};

  `FMFD_ASSERT_NOW(a_flags_excl, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]))
  `FMFD_ASSERT_NOW(a_zero_unchanged, clk, rst, m_tvalid && !m_tuser[0], m_tdata == 24'd0)
  `FMFD_ASSERT_NOW(a_min_offset, clk, rst, m_tvalid && m_tuser[0], m_tdata >= 24'd7)
  `FMFD_ASSERT_NEXT(a_last_to_out, clk, rst, advance && in_beat.last_byte, m_tvalid)

endmodule

### tb/sv/fence_verdict_checker.sv
// ----------------------------------------------------------------------------
// Front-matter fence verdict checker
// Watches the config port and both stream channels of the fence detector. It
// keeps its own scan of each document and queues the verdict due on the final
// byte. Each result beat is compared field by field with the oldest queued
// verdict. It hands the mismatch count and the queue depth to the bench top.
// ----------------------------------------------------------------------------
module fence_verdict_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          mismatch_count,
  output int          pending_verdicts
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] BOM_0    = 8'hEF;
  localparam logic [7:0] BOM_1    = 8'hBB;
  localparam logic [7:0] BOM_2    = 8'hBF;

  typedef enum logic [3:0] {
    SCAN_BOM0, SCAN_BOM1, SCAN_BOM2, SCAN_OPEN_FIRST, SCAN_OPEN_MARK,
    SCAN_OPEN_BLANKS, SCAN_OPEN_CR, SCAN_LINE_START, SCAN_CLOSE_MARK,
    SCAN_CLOSE_BLANKS, SCAN_CLOSE_CR, SCAN_SKIP
  } scan_phase_t;

  typedef enum logic [1:0] {FENCE_NONE, FENCE_DASH, FENCE_PLUS, FENCE_DOT} fence_char_t;

  typedef enum logic [1:0] {
    DOC_PENDING, DOC_STRIPPED, DOC_UNCHANGED, DOC_LIMIT
  } doc_outcome_t;

  scan_phase_t                    scan_phase;
  logic [fmfd_pkg::POS_W-1:0]     byte_pos;
  logic [fmfd_pkg::POS_W-1:0]     keep_offset;
  fence_char_t                    fence_kind;
  logic [1:0]                     fence_count;
  logic [fmfd_pkg::LINE_W-1:0]    lines_tried;
  logic [fmfd_pkg::LINE_W-1:0]    line_limit;
  doc_outcome_t                   doc_outcome;
  fmfd_pkg::result_t              verdicts[$];
  int                             errors = 0;

  function automatic fence_char_t char_kind(input logic [7:0] b);
    case (b)
      CH_DASH: return FENCE_DASH;
      CH_PLUS: return FENCE_PLUS;
      CH_DOT:  return FENCE_DOT;
      default: return FENCE_NONE;
    endcase
  endfunction

  function automatic logic [7:0] kind_char(input fence_char_t k);
    case (k)
      FENCE_DASH: return CH_DASH;
      FENCE_PLUS: return CH_PLUS;
      default:    return CH_DOT;
    endcase
  endfunction

  task automatic clear_scan();
    scan_phase  = SCAN_BOM0;
    byte_pos    = '0;
    keep_offset = '0;
    fence_kind  = FENCE_NONE;
    fence_count = '0;
    lines_tried = '0;
    doc_outcome = DOC_PENDING;
  endtask

  task automatic open_fence(input fence_char_t k);
    if (k == FENCE_DASH || k == FENCE_PLUS) begin
      fence_kind  = k;
      fence_count = 2'd1;
      scan_phase  = SCAN_OPEN_MARK;
    end else begin
      doc_outcome = DOC_UNCHANGED;
    end
  endtask

  task automatic scan_byte(input logic [7:0] b);
    fence_char_t k;
    logic        blank;
    k     = char_kind(b);
    blank = (b == CH_SPACE) || (b == CH_TAB);
    case (scan_phase)
      SCAN_BOM0: begin
        if (b == BOM_0) scan_phase = SCAN_BOM1;
        else open_fence(k);
      end
      SCAN_BOM1: begin
        if (b == BOM_1) scan_phase = SCAN_BOM2;
        else doc_outcome = DOC_UNCHANGED;
      end
      SCAN_BOM2: begin
        if (b == BOM_2) scan_phase = SCAN_OPEN_FIRST;
        else doc_outcome = DOC_UNCHANGED;
      end
      SCAN_OPEN_FIRST: open_fence(k);
      SCAN_OPEN_MARK: begin
        if (b == kind_char(fence_kind)) begin
          fence_count = fence_count + 2'd1;
          if (fence_count >= 2'd3) scan_phase = SCAN_OPEN_BLANKS;
        end else begin
          doc_outcome = DOC_UNCHANGED;
        end
      end
      SCAN_OPEN_BLANKS: begin
        if (!blank) begin
          if (b == CH_LF) scan_phase = SCAN_LINE_START;
          else if (b == CH_CR) scan_phase = SCAN_OPEN_CR;
          else doc_outcome = DOC_UNCHANGED;
        end
      end
      SCAN_OPEN_CR: begin
        if (b == CH_LF) scan_phase = SCAN_LINE_START;
        else doc_outcome = DOC_UNCHANGED;
      end
      SCAN_LINE_START: begin
        if (lines_tried >= line_limit) begin
          doc_outcome = DOC_LIMIT;
        end else begin
          lines_tried = lines_tried + 1'b1;
          fence_kind  = k;
          if (k != FENCE_NONE) begin
            fence_count = 2'd1;
            scan_phase  = SCAN_CLOSE_MARK;
          end else begin
            scan_phase = (b == CH_LF) ? SCAN_LINE_START : SCAN_SKIP;
          end
        end
      end
      SCAN_CLOSE_MARK: begin
        if (b == kind_char(fence_kind)) begin
          fence_count = fence_count + 2'd1;
          if (fence_count >= 2'd3) scan_phase = SCAN_CLOSE_BLANKS;
        end else begin
          scan_phase = (b == CH_LF) ? SCAN_LINE_START : SCAN_SKIP;
        end
      end
      SCAN_CLOSE_BLANKS: begin
        if (!blank) begin
          if (b == CH_LF) begin
            keep_offset = byte_pos + 1'b1;
            doc_outcome = DOC_STRIPPED;
          end else if (b == CH_CR) begin
            scan_phase = SCAN_CLOSE_CR;
          end else begin
            scan_phase = SCAN_SKIP;
          end
        end
      end
      SCAN_CLOSE_CR: begin
        if (b == CH_LF) begin
          keep_offset = byte_pos + 1'b1;
          doc_outcome = DOC_STRIPPED;
        end else begin
          scan_phase = (b == CH_LF) ? SCAN_LINE_START : SCAN_SKIP;
        end
      end
      default: begin
        if (b == CH_LF) scan_phase = SCAN_LINE_START;
      end
    endcase
  endtask

  task automatic take_beat(input logic [7:0] b, input logic last);
    fmfd_pkg::result_t verdict;
    if (doc_outcome == DOC_PENDING) begin
      if (byte_pos >= fmfd_pkg::MAX_POS) begin
        doc_outcome = DOC_LIMIT;
      end else begin
        scan_byte(b);
        byte_pos = byte_pos + 1'b1;
      end
    end
    if (last) begin
      if (doc_outcome == DOC_PENDING) begin
        if (scan_phase == SCAN_CLOSE_BLANKS) begin
          keep_offset = byte_pos;
          doc_outcome = DOC_STRIPPED;
        end else if (scan_phase == SCAN_LINE_START && lines_tried >= line_limit) begin
          doc_outcome = DOC_LIMIT;
        end else begin
          doc_outcome = DOC_UNCHANGED;
        end
      end
      verdict.body_offset = (doc_outcome == DOC_STRIPPED) ? keep_offset : '0;
      verdict.stripped    = (doc_outcome == DOC_STRIPPED);
      verdict.limit_hit   = (doc_outcome == DOC_LIMIT);
      verdicts.push_back(verdict);
      clear_scan();
    end
  endtask

  task automatic note_mismatch(input string what, input fmfd_pkg::result_t want,
                               input fmfd_pkg::result_t got);
    errors++;
    if (errors <= 10)
      $display({"mismatch (%s): expected offset=%0d stripped=%0b limit_hit=%0b,",
                " got offset=%0d stripped=%0b limit_hit=%0b"},
               what, want.body_offset, want.stripped, want.limit_hit,
               got.body_offset, got.stripped, got.limit_hit);
  endtask

  always @(posedge clk) begin : monitor
    fmfd_pkg::result_t got;
    fmfd_pkg::result_t want;
    if (rst) begin
      clear_scan();
      line_limit = fmfd_pkg::LINE_LIMIT_RESET;
      verdicts.delete();
    end else begin
      if (cfg_wr_en) line_limit = cfg_wr_data;
      if (m_tvalid && m_tready) begin
        got.body_offset = m_tdata[fmfd_pkg::OFFSET_W-1:0];
        got.stripped    = m_tuser[0];
        got.limit_hit   = m_tuser[1];
        if (verdicts.size() == 0) begin
          want = '0;
          note_mismatch("result beat with none expected", want, got);
        end else begin
          want = verdicts.pop_front();
          if (got.body_offset !== want.body_offset || got.stripped !== want.stripped ||
              got.limit_hit !== want.limit_hit)
            note_mismatch("wrong verdict", want, got);
        end
      end
      if (s_tvalid && s_tready) take_beat(s_tdata, s_tlast);
    end
    mismatch_count   <= errors;
    pending_verdicts <= verdicts.size();
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Front-matter fence detector bench
// Feeds directed and random documents byte by byte with random gaps on both
// sides and a long result hold-off, rewriting line_limit between runs. The
// checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         HOLD_CYCLES    = 600;
  localparam int         PHASE_BYTES    = 280;
  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_LF          = 8'h0A;
  localparam logic [7:0] CH_CR          = 8'h0D;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_PLUS        = 8'h2B;
  localparam logic [7:0] CH_DASH        = 8'h2D;
  localparam logic [7:0] CH_DOT         = 8'h2E;
  localparam logic [7:0] CH_X           = 8'h78;
  localparam logic [7:0] BOM_0          = 8'hEF;
  localparam logic [7:0] BOM_1          = 8'hBB;
  localparam logic [7:0] BOM_2          = 8'hBF;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_tvalid    = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata     = '0;
  logic        s_tlast     = 1'b0;
  logic        m_tvalid;
  logic        m_tready    = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  int          mismatch_count;
  int          pending_verdicts;
  bit          hold_request = 1'b0;
  bit          hold_done    = 1'b0;
  int          bytes_sent   = 0;
  int          idle_cycles  = 0;
  logic [7:0]  doc[$];

  front_matter_fence_detector i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  fence_verdict_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .mismatch_count   (mismatch_count),
    .pending_verdicts (pending_verdicts)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [7:0] pick_text_char();
    string pool;
    pool = "ab: -+.\t\015z#";
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic last, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_doc(input bit steady);
    int i;
    steady = steady || ($urandom_range(0, 3) == 0);
    for (i = 0; i < doc.size(); i++)
      send_beat(doc[i], i == doc.size() - 1, steady ? 0 : pick_gap());
    bytes_sent += doc.size();
    doc.delete();
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) doc.push_back(s[i]);
    send_doc(1'b0);
  endtask

  task automatic add_bom(input int n);
    if (n > 0) doc.push_back(BOM_0);
    if (n > 1) doc.push_back(BOM_1);
    if (n > 2) doc.push_back(BOM_2);
  endtask

  task automatic set_line_limit(input logic [15:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic add_fence_line(input bit opening);
    logic [7:0] c;
    int         r;
    int         i;
    r = $urandom_range(0, 9);
    if (opening) c = (r == 0) ? CH_DOT : ((r < 5) ? CH_DASH : CH_PLUS);
    else c = (r < 4) ? CH_DASH : ((r < 7) ? CH_PLUS : CH_DOT);
    for (i = 0; i < 3; i++)
      doc.push_back(($urandom_range(0, 11) == 0) ? pick_text_char() : c);
    repeat ($urandom_range(0, 3)) doc.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    r = $urandom_range(0, 19);
    if (r < 10) begin
      doc.push_back(CH_LF);
    end else if (r < 17) begin
      doc.push_back(CH_CR);
      doc.push_back(CH_LF);
    end else if (r < 18) begin
      doc.push_back(CH_CR);
      doc.push_back(CH_X);
      doc.push_back(CH_LF);
    end else if (r < 19) begin
      doc.push_back(CH_X);
      doc.push_back(CH_LF);
    end
  endtask

  task automatic add_text_line();
    repeat ($urandom_range(0, 8)) doc.push_back(pick_text_char());
    if ($urandom_range(0, 2) == 0) doc.push_back(CH_CR);
    doc.push_back(CH_LF);
  endtask

  task automatic build_doc();
    int r;
    int cut;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 20)) doc.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: add_bom(3);
      3:       add_bom(2);
      4:       add_bom(1);
      default: ;
    endcase
    add_fence_line(1'b1);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 3) == 0) add_fence_line(1'b0);
      else add_text_line();
    end
    if ($urandom_range(0, 9) < 7) add_fence_line(1'b0);
    repeat ($urandom_range(0, 2)) add_text_line();
    if (r >= 90 && doc.size() > 1) begin
      cut = $urandom_range(1, doc.size() - 1);
      while (doc.size() > cut) doc.delete(doc.size() - 1);
    end
    if (doc.size() == 0) doc.push_back(pick_text_char());
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
        else repeat ($urandom_range(1, 24)) @(posedge clk);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: stall = 0;
          4, 5, 6, 7: stall = $urandom_range(1, 3);
          8:          stall = $urandom_range(4, 10);
          default:    stall = $urandom_range(20, 80);
        endcase
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [15:0] phase_limits[6];
    int          p;
    int          phase_start;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed documents at the reset line_limit
    send_text("---\na: 1\n---\nbody\n");
    add_bom(3);
    send_text("+++ \t\015\nk\015\n+++\t\015\nrest");
    send_text("---\n...");
    send_text("---\n---  ");
    send_text("...\nx\n...\n");
    add_bom(2);
    send_text("x---\n---\n");
    add_bom(1);
    send_text("---\n");
    send_text("--- \t");
    send_text("---\015");
    send_text("---\015x\n---\n");
    send_text("---\n---\015x\n+++\015\n");
    send_text("---\n");
    send_text("-+-\n---\n");
    send_text("---\n---x\n--\n-.-\n+++\n");
    doc.push_back(8'h00);
    send_doc(1'b0);
    doc.push_back(8'hFF);
    send_doc(1'b0);

    set_line_limit(16'd1);
    send_text("---\nx\n---\n");
    send_text("---\nab\n");
    send_text("---\n---\n");

    phase_limits[0] = 16'd2;
    phase_limits[1] = 16'd65535;
    phase_limits[2] = 16'd1;
    phase_limits[3] = 16'($urandom_range(1, 6));
    phase_limits[4] = 16'd3;
    phase_limits[5] = 16'($urandom_range(4, 65535));
    for (p = 0; p < 6; p++) begin
      set_line_limit(phase_limits[p]);
      phase_start = bytes_sent;
      if (p == 2) begin
        // results pile up while the receiver is held off
        hold_request = 1'b1;
        repeat (40) begin
          repeat ($urandom_range(1, 3)) doc.push_back(pick_text_char());
          send_doc(1'b1);
        end
      end
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_doc();
        send_doc(1'b0);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/fmfd_pkg.sv
hdl/fmfd_in_stage.sv
hdl/fmfd_scan.sv
hdl/fmfd_out_stage.sv
hdl/front_matter_fence_detector.sv
tb/sv/fence_verdict_checker.sv
tb/sv/tb.sv
